@@ hw/rtl/psrl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_pkg
// Shared types, constants and helper functions of the per-source limiter.
// ----------------------------------------------------------------------------
package psrl_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int WAYS          = 4;
    localparam int SETS          = TABLE_ENTRIES / WAYS;
    localparam int SET_W         = $clog2(SETS);
    localparam int WAY_W         = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LRU_W         = WAYS * WAY_W;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 32;
    localparam int TIME_W  = 64;
    localparam int WIN_W   = 40;
    localparam int LIM_W   = 32;
    localparam int CFG_W   = 40;
    localparam int IDX_W   = 1;
    localparam int DROPS_W = 64;

    localparam logic [15:0]  MIN_EXAMINED_LENGTH = 16'd34;
    localparam logic [15:0]  IPV4_TYPE           = 16'h0800;
    localparam logic [31:0]  HASH_MULT           = 32'h9E3779B1;
    localparam logic [LIM_W-1:0] RATE_LIMIT_RESET = LIM_W'(1000);
    localparam logic [WIN_W-1:0] WINDOW_RESET     = WIN_W'(1000000000);

    localparam logic [IDX_W-1:0] REG_RATE_LIMIT = 1'b0;
    localparam logic [IDX_W-1:0] REG_WINDOW     = 1'b1;

    typedef enum logic [2:0] {
        OUT_NOT_EXAMINED = 3'd0,
        OUT_NEW_FLOW     = 3'd1,
        OUT_RESTART      = 3'd2,
        OUT_COUNTED      = 3'd3,
        OUT_DROPPED      = 3'd4
    } t_outcome;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic hash;
        logic read;
        logic update;
        logic out_valid;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
    } t_status;

    // Reset LRU order: way 0 is least recently used, stored at the low slot.
    function automatic logic [LRU_W-1:0] lru_reset_order();
        logic [LRU_W-1:0] v;
        v = '0;
        for (int i = 0; i < WAYS; i++) begin
            v[i*WAY_W +: WAY_W] = WAY_W'(i);
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/psrl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_ctrl
// Sequencer: clearing pass after reset, then hash, read, update and output.
// ----------------------------------------------------------------------------
module psrl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_out_ready,
    input  psrl_pkg::t_status i_status,
    output logic            o_ready,
    output psrl_pkg::t_cmd  o_cmd
);
    import psrl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (i_status.clear_done) n_state = ST_IDLE;
            ST_IDLE:   if (i_valid) n_state = ST_HASH;
            ST_HASH:   n_state = ST_READ;
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = i_valid ? ST_HASH : ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_CLEAR:  o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_ready = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_HASH:   o_cmd.hash = 1'b1;
            ST_READ:   o_cmd.read = 1'b1;
            ST_UPDATE: o_cmd.update = 1'b1;
            ST_OUT: begin
                o_cmd.out_valid = 1'b1;
                o_ready = i_out_ready;
                o_cmd.load = i_out_ready && i_valid;
            end
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/psrl_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_datapath
// Flow table memories, hash, hit detection, LRU update and counters.
// ----------------------------------------------------------------------------
module psrl_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  psrl_pkg::t_cmd              i_cmd,
    output psrl_pkg::t_status           o_status,
    input  logic                        i_cfg_we,
    input  logic [psrl_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [psrl_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [15:0]                 i_frame_length,
    input  logic [15:0]                 i_ether_type,
    input  logic [31:0]                 i_source_address,
    input  logic [63:0]                 i_arrival_time,
    output logic                        o_drop,
    output logic [2:0]                  o_outcome,
    output logic [63:0]                 o_drop_total
);
    import psrl_pkg::*;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  start;
    } t_entry;

    logic [LRU_W-1:0] mem_lru [SETS];

    logic [LIM_W-1:0]   r_rate_limit;
    logic [WIN_W-1:0]   r_window;
    logic [DROPS_W-1:0] r_drops;
    logic [SET_W:0]     r_clr_cnt;

    logic               r_examine;
    logic [KEY_W-1:0]   r_key;
    logic [TIME_W-1:0]  r_now;
    logic [31:0]        r_hash;
    logic [SET_W-1:0]   r_set;
    t_entry             rows [WAYS];
    logic [LRU_W-1:0]   r_lru;
    logic               r_drop;
    logic [2:0]         r_outcome;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_limit <= RATE_LIMIT_RESET;
            r_window     <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RATE_LIMIT: r_rate_limit <= i_cfg_data[LIM_W-1:0];
                REG_WINDOW:     r_window     <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear && !r_clr_cnt[SET_W]) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end
    assign o_status.clear_done = r_clr_cnt[SET_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_examine <= (i_frame_length >= MIN_EXAMINED_LENGTH)
                         && (i_ether_type == IPV4_TYPE);
            r_key     <= i_source_address;
            r_now     <= i_arrival_time;
        end
        if (i_cmd.hash) begin
            r_hash <= r_key * HASH_MULT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_set <= SET_W'((r_hash ^ (r_hash >> 16)) % SETS);
        end
    end

    // Set index is combinational from the hash register for the read cycle.
    logic [SET_W-1:0] set_rd;
    assign set_rd = SET_W'((r_hash ^ (r_hash >> 16)) % SETS);

    // Update-cycle decision logic.
    logic [WAY_W-1:0]   hit_way, free_way, victim, use_way;
    logic               hit, has_free;
    t_entry             cur, wr_entry;
    logic [TIME_W-1:0]  elapsed;
    logic               expired;
    logic [COUNT_W-1:0] cnt_inc;
    logic [LRU_W-1:0]   lru_new;
    logic               do_drop;
    logic [2:0]         outc;
    logic [WAY_W-1:0]   pos;

    always_comb begin
        hit = 1'b0; hit_way = '0; has_free = 1'b0; free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rows[w].valid) begin
                if (rows[w].key == r_key) begin
                    hit = 1'b1; hit_way = WAY_W'(w);
                end
            end else begin
                has_free = 1'b1; free_way = WAY_W'(w);
            end
        end
        victim  = has_free ? free_way : r_lru[WAY_W-1:0];
        use_way = hit ? hit_way : victim;
        cur     = rows[use_way];
        elapsed = r_now - cur.start;
        expired = elapsed > TIME_W'(r_window);
        cnt_inc = (cur.count == '1) ? cur.count : cur.count + 1'b1;
        do_drop = 1'b0;
        wr_entry.valid = 1'b1;
        wr_entry.key   = r_key;
        wr_entry.count = COUNT_W'(1);
        wr_entry.start = r_now;
        if (!hit) begin
            outc = OUT_NEW_FLOW;
        end else if (expired) begin
            outc = OUT_RESTART;
        end else begin
            wr_entry.count = cnt_inc;
            wr_entry.start = cur.start;
            if (cnt_inc > r_rate_limit) begin
                do_drop = 1'b1;
                outc = OUT_DROPPED;
            end else begin
                outc = OUT_COUNTED;
            end
        end
        // Move use_way to the most recent slot, shifting later slots down.
        pos = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (r_lru[i*WAY_W +: WAY_W] == use_way) pos = WAY_W'(i);
        end
        lru_new = r_lru;
        for (int i = 0; i < WAYS - 1; i++) begin
            if (WAY_W'(i) >= pos) lru_new[i*WAY_W +: WAY_W] = r_lru[(i+1)*WAY_W +: WAY_W];
        end
        lru_new[(WAYS-1)*WAY_W +: WAY_W] = use_way;
    end

    // Entry rows live in separate per-way memories for one read and write port each.
    genvar gw;
    generate
        for (gw = 0; gw < WAYS; gw++) begin : g_way
            t_entry mem_way [SETS];
            t_entry r_row;

            always_ff @(posedge i_clk) begin
                if (i_cmd.clear && !r_clr_cnt[SET_W]) begin
                    mem_way[r_clr_cnt[SET_W-1:0]] <= '0;
                end else if (i_cmd.update && r_examine && use_way == WAY_W'(gw)) begin
                    mem_way[r_set] <= wr_entry;
                end
                if (i_cmd.read) begin
                    r_row <= mem_way[set_rd];
                end
            end

            assign rows[gw] = r_row;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear && !r_clr_cnt[SET_W]) begin
            mem_lru[r_clr_cnt[SET_W-1:0]] <= lru_reset_order();
        end else if (i_cmd.update && r_examine) begin
            mem_lru[r_set] <= lru_new;
        end
        if (i_cmd.read) begin
            r_lru <= mem_lru[set_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drops <= '0;
        end else if (i_cmd.update && r_examine && do_drop) begin
            r_drops <= r_drops + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_drop    <= r_examine && do_drop;
            r_outcome <= r_examine ? outc : OUT_NOT_EXAMINED;
        end
    end

    assign o_drop       = r_drop;
    assign o_outcome    = r_outcome;
    assign o_drop_total = r_drops;

endmodule

@@ hw/rtl/per_source_window_rate_limiter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_window_rate_limiter_top
// Per-source fixed-window packet rate limiter with a set-associative table.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// input    in         i_valid / o_ready       frame_length, ether_type,
//                                             source_address, arrival_time
// output   out        o_valid / i_ready       drop, outcome, drop_total
// config   in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// Each word passes through hash multiply, set read, update with write-back,
// and the result. The sequencer runs one word
// at a time, so a new word is taken in the cycle its predecessor's result is
// taken. After reset a clearing pass walks every set; no word
// is accepted during it. A stalled result holds the block.
// ----------------------------------------------------------------------------
module per_source_window_rate_limiter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_frame_length,
    input  logic [15:0] i_ether_type,
    input  logic [31:0] i_source_address,
    input  logic [63:0] i_arrival_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_drop,
    output logic [2:0]  o_outcome,
    output logic [63:0] o_drop_total,
    input  logic        i_cfg_we,
    input  logic [psrl_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [psrl_pkg::CFG_W-1:0] i_cfg_data
);
    import psrl_pkg::*;

    t_cmd    cmd;
    t_status status;

    psrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_ready     (o_ready),
        .o_cmd       (cmd)
    );

    psrl_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_frame_length   (i_frame_length),
        .i_ether_type     (i_ether_type),
        .i_source_address (i_source_address),
        .i_arrival_time   (i_arrival_time),
        .o_drop           (o_drop),
        .o_outcome        (o_outcome),
        .o_drop_total     (o_drop_total)
    );

    assign o_valid = cmd.out_valid;

    a_drop_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_drop == (o_outcome == OUT_DROPPED)))
        else $error("drop flag disagrees with outcome");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input accepted while result stalled");

    a_total_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_drop_total))
        else $error("drop total moved while result stalled");

endmodule
